// ===== sv/rrs_pkg.sv =====
package rrs_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	// wide enough for the sum of all sizes and for a 20-bit offset, plus a carry
	localparam int SUM_W  = (((16 + CNT_W) > 20) ? (16 + CNT_W) : 20) + 1;

	localparam logic [19:0] MAX20 = 20'hFFFFF;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_ADD  = 2'd0;
	localparam func_t FUNC_SEEK = 2'd1;
	localparam func_t FUNC_POS  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		func_t       func;
		logic [15:0] record_size;
		logic [31:0] record_handle;
		logic [19:0] seek_offset;
		logic [7:0]  record_index;
		logic [15:0] offset_in_record;
	} req_t;

	typedef struct packed {
		logic        evicted_valid;
		logic [31:0] evicted_handle;
		logic        found;
		logic [31:0] found_handle;
		logic [3:0]  found_slot;
		logic [15:0] byte_in_record;
		logic [19:0] file_position;
		logic [19:0] total_length;
	} rsp_t;

	typedef struct packed {
		logic [15:0] size;
		logic [31:0] handle;
	} rec_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	function automatic logic [19:0] sat20(input logic [SUM_W-1:0] v);
		logic [19:0] r;
		if (v > SUM_W'(MAX20)) begin
			r = MAX20;
		end else begin
			r = v[19:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/rrs_req_if.sv =====
interface rrs_req_if;
	import rrs_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rrs_rsp_if.sv =====
interface rrs_rsp_if;
	import rrs_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rrs_cell.sv =====
module rrs_cell (
	input  logic              clk,
	input  rrs_pkg::cell_ctl_t ctl,
	input  rrs_pkg::rec_t     load_rec,
	input  rrs_pkg::rec_t     shift_rec,
	output rrs_pkg::rec_t     rec
);
	import rrs_pkg::*;

	rec_t rec_q;

	// load writes a new record in place; shift takes the neighbor's record
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rec_q <= load_rec;
		end else if (ctl.shift) begin
			rec_q <= shift_rec;
		end
	end

	assign rec = rec_q;

endmodule

// ===== sv/ring_record_store_offset_lookup.sv =====
// Add and unused codes: result registered at the accepting edge.
// Seek and position query: the record chain rotates once through the head cell, one
// record summed per cycle, then the result is registered once the result register frees.
// One item at a time; the next is accepted in ST_IDLE once the result register frees.
// arst_n clears the ring (empty), the control state and the result valid; records stay.
module ring_record_store_offset_lookup (
	input logic clk,
	input logic arst_n,
	rrs_req_if.sink   req,
	rrs_rsp_if.source rsp
);
	import rrs_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  k_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [SUM_W-1:0]  total_q;
	logic [SUM_W-1:0]  acc_q;

	func_t       func_q;
	logic [19:0] coff_q;
	logic [7:0]  ridx_q;
	logic [15:0] roff_q;
	logic        done_q;
	logic        found_q;
	logic [31:0] fhandle_q;
	logic [3:0]  fslot_q;
	logic [15:0] fbyte_q;

	rsp_t rsp_q;
	logic rsp_valid_q;

	rec_t      cell_rec [SLOTS];
	cell_ctl_t cell_ctl [SLOTS];
	rec_t      load_rec;
	rec_t      tail_in;
	rec_t      head;

	logic full, req_fire, rsp_free, req_ready, walk_step, fin_load;
	logic add_fire, evict, walk_fire, quick_fire, active;
	logic [SUM_W-1:0]  total_add, sum;
	logic [15:0]       addend, clamp;
	logic              at_idx, hit;
	logic [SLOT_W:0]   slot_sum;
	logic [SLOT_W-1:0] slot_mod;
	logic [7:0]        slot_wide;
	rsp_t              quick_rsp, walk_rsp;

	assign head     = cell_rec[0];
	assign full     = (count_q == CNT_W'(SLOTS));
	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign req_fire = req.valid && req_ready;

	assign add_fire   = req_fire && (req.data.func == FUNC_ADD);
	assign evict      = add_fire && full;
	assign walk_fire  = req_fire && ((req.data.func == FUNC_SEEK) || (req.data.func == FUNC_POS));
	assign quick_fire = req_fire && !walk_fire;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (walk_fire) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (k_q == CNT_W'(SLOTS - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_ready = 1'b0;
		walk_step = 1'b0;
		fin_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:   req_ready = rsp_free;
			ST_WALK:   walk_step = 1'b1;
			ST_FINISH: fin_load  = rsp_free;
			default: ;
		endcase
	end

	assign req.ready = req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// record chain: head is the oldest record, tail the last cell
	assign load_rec.size   = req.data.record_size;
	assign load_rec.handle = req.data.record_handle;
	assign tail_in         = walk_step ? head : load_rec;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		assign cell_ctl[i].load  = add_fire && !full && (count_q[SLOT_W-1:0] == SLOT_W'(i));
		assign cell_ctl[i].shift = walk_step || evict;
		if (i == SLOTS - 1) begin : g_tail
			rrs_cell u_cell (
				.clk       (clk),
				.ctl       (cell_ctl[i]),
				.load_rec  (load_rec),
				.shift_rec (tail_in),
				.rec       (cell_rec[i])
			);
		end else begin : g_body
			rrs_cell u_cell (
				.clk       (clk),
				.ctl       (cell_ctl[i]),
				.load_rec  (load_rec),
				.shift_rec (cell_rec[i+1]),
				.rec       (cell_rec[i])
			);
		end
	end

	// ring bookkeeping
	assign total_add = total_q + SUM_W'(req.data.record_size)
		- (full ? SUM_W'(head.size) : SUM_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			oldest_q <= '0;
			total_q  <= '0;
		end else if (add_fire) begin
			total_q <= total_add;
			if (full) begin
				oldest_q <= (oldest_q == SLOT_W'(SLOTS - 1)) ? '0 : oldest_q + 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// walk datapath: one record from the head cell per cycle
	assign active = (k_q < count_q);
	assign at_idx = (8'(k_q) == ridx_q);
	assign clamp  = (head.size < roff_q) ? head.size : roff_q;
	assign addend = ((func_q == FUNC_POS) && at_idx) ? clamp : head.size;
	assign sum    = acc_q + SUM_W'(addend);
	assign hit    = (sum > SUM_W'(coff_q));

	assign slot_sum  = (SLOT_W+1)'(oldest_q) + (SLOT_W+1)'(k_q[SLOT_W-1:0]);
	assign slot_mod  = (slot_sum >= (SLOT_W+1)'(SLOTS)) ?
		SLOT_W'(slot_sum - (SLOT_W+1)'(SLOTS)) : slot_sum[SLOT_W-1:0];
	assign slot_wide = 8'(slot_mod);

	always_ff @(posedge clk) begin
		if (walk_fire) begin
			func_q  <= req.data.func;
			coff_q  <= req.data.seek_offset;
			ridx_q  <= req.data.record_index;
			roff_q  <= req.data.offset_in_record;
			k_q     <= '0;
			acc_q   <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			fhandle_q <= '0;
			fslot_q   <= '0;
			fbyte_q   <= '0;
		end else if (walk_step) begin
			k_q <= k_q + 1'b1;
			if (active && !done_q) begin
				if (func_q == FUNC_SEEK) begin
					if (hit) begin
						found_q   <= 1'b1;
						done_q    <= 1'b1;
						fhandle_q <= head.handle;
						fslot_q   <= slot_wide[3:0];
						fbyte_q   <= 16'(SUM_W'(coff_q) - acc_q);
					end else begin
						acc_q <= sum;
					end
				end else begin
					acc_q <= sum;
					if (at_idx) begin
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// result register
	always_comb begin
		quick_rsp = '0;
		if (req.data.func == FUNC_ADD) begin
			quick_rsp.evicted_valid  = full;
			quick_rsp.evicted_handle = full ? head.handle : 32'd0;
			quick_rsp.total_length   = sat20(total_add);
		end else begin
			quick_rsp.total_length = sat20(total_q);
		end
	end

	always_comb begin
		walk_rsp = '0;
		walk_rsp.total_length = sat20(total_q);
		if (func_q == FUNC_SEEK) begin
			walk_rsp.found          = found_q;
			walk_rsp.found_handle   = fhandle_q;
			walk_rsp.found_slot     = fslot_q;
			walk_rsp.byte_in_record = fbyte_q;
		end else begin
			walk_rsp.file_position = sat20(acc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (quick_fire) begin
			rsp_q <= quick_rsp;
		end else if (fin_load) begin
			rsp_q <= walk_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (quick_fire || fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_ready)
		else $error("item accepted during a walk");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("record count beyond ring size");

	a_walk_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && k_q == CNT_W'(SLOTS - 1)) |=> (state_q == ST_FINISH))
		else $error("walk did not end after one full rotation");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && rsp_free) |=> rsp_valid_q)
		else $error("walk result not registered");

endmodule
